// ===== src/pdvc_pkg.sv =====
package pdvc_pkg;

  // field widths of one beat
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned ID_W    = 12;
  localparam int unsigned VAL_W   = 12;
  localparam int unsigned VISIT_W = 2;
  localparam int unsigned CNT_W   = 13;

  // stream packing
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // request kinds carried on in_tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_t;

  // control sequencer
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // result of one read-modify-write step
  typedef struct packed {
    logic               visit_we;
    logic [VISIT_W-1:0] visit_wdata;
    logic               value_we;
    logic [CNT_W-1:0]   value_wdata;
    logic [CNT_W-1:0]   total_nxt;
    logic [CNT_W-1:0]   result;
    logic               misuse;
  } upd_t;

endpackage

// ===== src/pdvc_ram.sv =====
module pdvc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/pdvc_update.sv =====
module pdvc_update #(
  parameter int unsigned NODES  = 4096,
  parameter int unsigned VALUES = 4096
) (
  input  logic [pdvc_pkg::REQ_W-1:0]   req,
  input  logic [pdvc_pkg::ID_W-1:0]    node_id,
  input  logic [pdvc_pkg::VAL_W-1:0]   node_value,
  input  logic                         extra_node,
  input  logic [pdvc_pkg::VISIT_W-1:0] visit_rd,
  input  logic [pdvc_pkg::CNT_W-1:0]   count_rd,
  input  logic [pdvc_pkg::CNT_W-1:0]   total,
  output pdvc_pkg::upd_t               upd
);
  import pdvc_pkg::*;

  logic node_ok;
  logic val_ok;
  logic do_up;
  logic do_down;
  logic q_add;

  // range checks against the configured store depths
  assign node_ok = 32'(node_id) < 32'(NODES);
  assign val_ok  = 32'(node_value) < 32'(VALUES);

  always_comb begin
    upd             = '0;
    upd.visit_wdata = visit_rd;
    upd.value_wdata = count_rd;
    upd.total_nxt   = total;
    do_up           = 1'b0;
    do_down         = 1'b0;
    q_add           = 1'b0;

    // decode request, step the visit count
    unique case (req)
      REQ_ADD: begin
        if (!node_ok || !val_ok || visit_rd >= 2'd2) begin
          upd.misuse = 1'b1;
        end else begin
          upd.visit_we    = 1'b1;
          upd.visit_wdata = visit_rd + 2'd1;
          if (visit_rd == 2'd1) begin
            do_down = 1'b1;
          end else begin
            do_up = 1'b1;
          end
        end
      end
      REQ_REMOVE: begin
        if (!node_ok || !val_ok || visit_rd == 2'd0) begin
          upd.misuse = 1'b1;
        end else begin
          upd.visit_we    = 1'b1;
          upd.visit_wdata = visit_rd - 2'd1;
          if (visit_rd == 2'd2) begin
            do_up = 1'b1;
          end else begin
            do_down = 1'b1;
          end
        end
      end
      REQ_QUERY: begin
        if (extra_node) begin
          if (!val_ok) begin
            upd.misuse = 1'b1;
          end else if (count_rd == '0) begin
            q_add = 1'b1;
          end
        end
      end
      default: begin
        upd.misuse = 1'b1;
      end
    endcase

    // value count with saturation, running total follows 0<->1 edges
    if (do_up && count_rd != COUNT_MAX) begin
      upd.value_we    = 1'b1;
      upd.value_wdata = count_rd + CNT_W'(1);
      if (count_rd == '0) begin
        upd.total_nxt = total + CNT_W'(1);
      end
    end
    if (do_down && count_rd != '0) begin
      upd.value_we    = 1'b1;
      upd.value_wdata = count_rd - CNT_W'(1);
      if (count_rd == CNT_W'(1) && total != '0) begin
        upd.total_nxt = total - CNT_W'(1);
      end
    end

    // reported count, saturating
    if (q_add && upd.total_nxt != COUNT_MAX) begin
      upd.result = upd.total_nxt + CNT_W'(1);
    end else begin
      upd.result = upd.total_nxt;
    end
  end

endmodule

// ===== src/path_distinct_value_counter_top.sv =====
// Flow: an accepted beat reads both memories, then the execute state computes and writes back
// and loads the output register; in_tready is low in execute, so items go through one at a time;
// the output register lets the next item in while a result waits.
// Reset: synchronous rst_n; afterwards a clearing pass over max(NODES, VALUES)
// addresses zeroes both memories with in_tready low.
module path_distinct_value_counter_top #(
  parameter int unsigned NODES  = 4096,
  parameter int unsigned VALUES = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: node_id[11:0], node_value[23:12], extra_node[24], zero[31:25]
  input  logic [pdvc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: req_type[1:0]
  input  logic [pdvc_pkg::REQ_W-1:0]           in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata: distinct_count[12:0], zero[15:13]
  output logic [pdvc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // out_tuser: misuse[0]
  output logic [0:0]                           out_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready
);
  import pdvc_pkg::*;

  localparam int unsigned NAW   = $clog2(NODES);
  localparam int unsigned VAW   = $clog2(VALUES);
  localparam int unsigned CLR_N = (NODES > VALUES) ? NODES : VALUES;
  localparam int unsigned CLW   = $clog2(CLR_N);

  state_t             state_r, state_nxt;
  logic [CLW-1:0]     clr_idx_r, clr_idx_nxt;
  logic [REQ_W-1:0]   req_r;
  logic [ID_W-1:0]    node_r;
  logic [VAL_W-1:0]   val_r;
  logic               extra_r;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]   out_count_r;
  logic               out_misuse_r;

  logic               accept;
  logic               commit;
  logic [31:0]        clr_ext;
  logic [31:0]        in_node_ext;
  logic [31:0]        in_val_ext;
  logic [31:0]        node_ext;
  logic [31:0]        val_ext;

  logic               visit_we, value_we;
  logic [NAW-1:0]     visit_waddr;
  logic [VAW-1:0]     value_waddr;
  logic [VISIT_W-1:0] visit_wdata, visit_rd;
  logic [CNT_W-1:0]   value_wdata, count_rd;
  upd_t               upd;

  assign accept = in_tvalid && in_tready;
  assign commit = (state_r == ST_EXEC) && (!out_valid_r || out_tready);

  assign clr_ext     = 32'(clr_idx_r);
  assign in_node_ext = 32'(in_tdata[ID_W-1:0]);
  assign in_val_ext  = 32'(in_tdata[ID_W+VAL_W-1:ID_W]);
  assign node_ext    = 32'(node_r);
  assign val_ext     = 32'(val_r);

  // sequencer: clear sweep, then accept / execute
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    in_tready   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + CLW'(1);
        if (clr_ext == 32'(CLR_N - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // item fields held for the execute state
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_tuser;
      node_r  <= in_tdata[ID_W-1:0];
      val_r   <= in_tdata[ID_W+VAL_W-1:ID_W];
      extra_r <= in_tdata[ID_W+VAL_W];
    end
  end

  // write port: clear sweep or write-back
  always_comb begin
    if (state_r == ST_CLEAR) begin
      visit_we    = clr_ext < 32'(NODES);
      value_we    = clr_ext < 32'(VALUES);
      visit_waddr = clr_ext[NAW-1:0];
      value_waddr = clr_ext[VAW-1:0];
      visit_wdata = '0;
      value_wdata = '0;
    end else begin
      visit_we    = commit && upd.visit_we;
      value_we    = commit && upd.value_we;
      visit_waddr = node_ext[NAW-1:0];
      value_waddr = val_ext[VAW-1:0];
      visit_wdata = upd.visit_wdata;
      value_wdata = upd.value_wdata;
    end
  end

  pdvc_ram #(
    .WIDTH (VISIT_W),
    .DEPTH (NODES)
  ) u_visit_ram (
    .clk   (clk),
    .we    (visit_we),
    .waddr (visit_waddr),
    .wdata (visit_wdata),
    .re    (accept),
    .raddr (in_node_ext[NAW-1:0]),
    .rdata (visit_rd)
  );

  pdvc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (VALUES)
  ) u_value_ram (
    .clk   (clk),
    .we    (value_we),
    .waddr (value_waddr),
    .wdata (value_wdata),
    .re    (accept),
    .raddr (in_val_ext[VAW-1:0]),
    .rdata (count_rd)
  );

  pdvc_update #(
    .NODES  (NODES),
    .VALUES (VALUES)
  ) u_update (
    .req        (req_r),
    .node_id    (node_r),
    .node_value (val_r),
    .extra_node (extra_r),
    .visit_rd   (visit_rd),
    .count_rd   (count_rd),
    .total      (total_r),
    .upd        (upd)
  );

  // running total and output register
  always_comb begin
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (commit) begin
      total_nxt     = upd.total_nxt;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_count_r  <= upd.result;
      out_misuse_r <= upd.misuse;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_count_r);
  assign out_tuser  = out_misuse_r;

endmodule
